>>> rtl/light_drop_detector_unit_macros.svh
// Assertion macros shared by the light drop detector checker.
// Uses the clk and rst_n names of the module that expands them.
`ifndef LIGHT_DROP_DETECTOR_UNIT_MACROS_SVH
`define LIGHT_DROP_DETECTOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LDD_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LDD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ldd_pkg.sv
// Light drop detector package: register codes, mode codes, fixed widths,
// and the command/status structs between controller and datapath.
package ldd_pkg;

    localparam int THR_W  = 10;
    localparam int MODE_W = 2;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int JV_W   = 10;
    localparam int BS_W   = 16;

    // Register index (paddr[2])
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_MODE      = 1'b1;

    localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_AVG    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HOLD   = 2'd2;

    localparam logic [THR_W-1:0]  THR_RESET  = 10'd50;
    localparam logic [MODE_W-1:0] MODE_RESET = MODE_SINGLE;

    typedef struct packed {
        logic prime_write;
        logic group_clear;
        logic group_add;
        logic load_v_sample;
        logic div_mul;
        logic div_fix;
        logic judge_mul;
        logic out_load;
        logic push;
    } dp_cmd_t;

    typedef struct packed {
        logic primed;
        logic group_last;
        logic det;
    } dp_status_t;

endpackage

>>> rtl/ldd_ctrl.sv
// Light drop detector controller: item sequencing, push count, result valid.
// Depends on ldd_pkg; drives ldd_dp through dp_cmd_t.
module ldd_ctrl #(
    parameter int GROUP = 5
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         sample_valid,
    output logic                         sample_ready,
    input  logic [ldd_pkg::MODE_W-1:0]   judge_mode,
    input  ldd_pkg::dp_status_t          status,
    output ldd_pkg::dp_cmd_t             cmd,
    output logic                         result_valid,
    input  logic                         result_ready
);

    localparam int PC_W = $clog2(GROUP + 1);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DIV_MUL   = 3'd1;
    localparam logic [2:0] S_DIV_FIX   = 3'd2;
    localparam logic [2:0] S_JUDGE_MUL = 3'd3;
    localparam logic [2:0] S_JUDGE     = 3'd4;
    localparam logic [2:0] S_PUSH      = 3'd5;

    logic [2:0]      state_reg, state_next;
    logic [PC_W-1:0] push_left_reg, push_left_next;
    logic            result_valid_reg, result_valid_next;
    logic            accept;

    assign sample_ready = (state_reg == S_IDLE);
    assign accept       = sample_valid && sample_ready;
    assign result_valid = result_valid_reg;

    always_comb
    begin
        cmd               = '0;
        state_next        = state_reg;
        push_left_next    = push_left_reg;
        result_valid_next = result_valid_reg && !result_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!status.primed)
                    begin
                        cmd.prime_write = 1'b1;
                    end
                    else if (judge_mode == ldd_pkg::MODE_SINGLE)
                    begin
                        cmd.group_clear   = 1'b1;
                        cmd.load_v_sample = 1'b1;
                        push_left_next    = PC_W'(1);
                        state_next        = S_JUDGE_MUL;
                    end
                    else
                    begin
                        cmd.group_add = 1'b1;
                        if (status.group_last)
                        begin
                            push_left_next = (judge_mode == ldd_pkg::MODE_AVG) ?
                                             PC_W'(GROUP) : '0;
                            state_next     = S_DIV_MUL;
                        end
                    end
                end
            end
            S_DIV_MUL:
            begin
                cmd.div_mul = 1'b1;
                state_next  = S_DIV_FIX;
            end
            S_DIV_FIX:
            begin
                cmd.div_fix     = 1'b1;
                cmd.group_clear = 1'b1;
                state_next      = S_JUDGE_MUL;
            end
            S_JUDGE_MUL:
            begin
                cmd.judge_mul = 1'b1;
                state_next    = S_JUDGE;
            end
            S_JUDGE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    cmd.out_load      = 1'b1;
                    result_valid_next = 1'b1;
                    if (!status.det && push_left_reg != '0)
                    begin
                        state_next = S_PUSH;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_PUSH:
            begin
                cmd.push       = 1'b1;
                push_left_next = push_left_reg - PC_W'(1);
                if (push_left_reg == PC_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            push_left_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            push_left_reg    <= push_left_next;
            result_valid_reg <= result_valid_next;
        end
    end

endmodule

>>> rtl/ldd_dp.sv
// Light drop detector datapath: baseline ring memory, running sum, group
// accumulator, divide by group size, threshold compare, result registers.
// Depends on ldd_pkg; controlled by ldd_ctrl.
module ldd_dp #(
    parameter int WINDOW      = 40,
    parameter int GROUP       = 5,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [SAMPLE_BITS-1:0]       sample,
    input  logic [ldd_pkg::THR_W-1:0]    drop_threshold,
    input  ldd_pkg::dp_cmd_t             cmd,
    output ldd_pkg::dp_status_t          status,
    output logic                         detected,
    output logic [ldd_pkg::JV_W-1:0]     judged_value,
    output logic [ldd_pkg::BS_W-1:0]     baseline_sum
);

    localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int PCNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
    localparam int SUMX_W = (SUM_W > ldd_pkg::BS_W) ? SUM_W : ldd_pkg::BS_W;
    localparam int VW     = (SAMPLE_BITS > ldd_pkg::JV_W) ? SAMPLE_BITS : ldd_pkg::JV_W;
    localparam int ACC_W  = SAMPLE_BITS + $clog2(GROUP);
    localparam int GCW    = $clog2(GROUP + 1);
    localparam int DIV_S  = ACC_W;
    localparam int M_W    = DIV_S + 1;
    localparam int PROD_W = ACC_W + M_W;
    localparam logic [M_W-1:0] RECIP = M_W'((2 ** DIV_S) / GROUP);
    localparam int RHS_W  = VW + 1 + $clog2(WINDOW + 1);

    logic [SAMPLE_BITS-1:0] ring_mem [WINDOW];
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic [PTR_W-1:0]       ptr_reg, ptr_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [PCNT_W-1:0]      prime_cnt_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic [GCW-1:0]         gcnt_reg;
    logic [ACC_W-1:0]       qest_reg;
    logic [VW-1:0]          v_reg;
    logic [RHS_W-1:0]       rhs_reg;
    logic                   det_reg;
    logic [ldd_pkg::JV_W-1:0] jv_reg;
    logic [ldd_pkg::BS_W-1:0] bs_reg;

    logic                   advance;
    logic [SAMPLE_BITS-1:0] wr_data;
    logic [PROD_W-1:0]      prod;
    logic [ACC_W-1:0]       rem;
    logic [ACC_W-1:0]       qcorr;
    logic [SUMX_W-1:0]      sum_x;

    assign advance  = cmd.prime_write || cmd.push;
    assign wr_data  = cmd.prime_write ? sample : v_reg[SAMPLE_BITS-1:0];
    assign ptr_next = !advance ? ptr_reg :
                      (ptr_reg == PTR_W'(WINDOW - 1)) ? '0 : ptr_reg + PTR_W'(1);

    always_comb
    begin
        sum_next = sum_reg;
        if (cmd.prime_write)
        begin
            sum_next = sum_reg + SUM_W'(sample);
        end
        else if (cmd.push)
        begin
            sum_next = sum_reg - SUM_W'(rd_data_reg) + SUM_W'(v_reg[SAMPLE_BITS-1:0]);
        end
    end

    // reciprocal estimate is exact or one low; the remainder check fixes it
    assign prod  = PROD_W'(acc_reg) * PROD_W'(RECIP);
    assign rem   = acc_reg - ACC_W'(qest_reg * ACC_W'(GROUP));
    assign qcorr = (rem >= ACC_W'(GROUP)) ? qest_reg + ACC_W'(1) : qest_reg;

    assign sum_x = SUMX_W'(sum_reg);

    assign status.primed     = (prime_cnt_reg == PCNT_W'(WINDOW));
    assign status.group_last = (GCW'(gcnt_reg + GCW'(1)) == GCW'(GROUP));
    assign status.det        = (RHS_W'(sum_reg) > rhs_reg);

    assign detected     = det_reg;
    assign judged_value = jv_reg;
    assign baseline_sum = bs_reg;

    // read port follows the next pointer so rd_data_reg is always ring[ptr_reg]
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ring_mem[ptr_reg] <= wr_data;
        end
        rd_data_reg <= ring_mem[ptr_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            sum_reg       <= '0;
            prime_cnt_reg <= '0;
            acc_reg       <= '0;
            gcnt_reg      <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
            sum_reg <= sum_next;
            if (cmd.prime_write)
            begin
                prime_cnt_reg <= prime_cnt_reg + PCNT_W'(1);
            end
            if (cmd.group_clear)
            begin
                acc_reg  <= '0;
                gcnt_reg <= '0;
            end
            else if (cmd.group_add)
            begin
                acc_reg  <= acc_reg + ACC_W'(sample);
                gcnt_reg <= gcnt_reg + GCW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_mul)
        begin
            qest_reg <= ACC_W'(prod >> DIV_S);
        end
        if (cmd.load_v_sample)
        begin
            v_reg <= VW'(sample);
        end
        else if (cmd.div_fix)
        begin
            v_reg <= VW'(qcorr);
        end
        if (cmd.judge_mul)
        begin
            rhs_reg <= RHS_W'(WINDOW) * (RHS_W'(v_reg) + RHS_W'(drop_threshold));
        end
        if (cmd.out_load)
        begin
            det_reg <= status.det;
            jv_reg  <= v_reg[ldd_pkg::JV_W-1:0];
            bs_reg  <= sum_x[ldd_pkg::BS_W-1:0];
        end
    end

endmodule

>>> rtl/light_drop_detector_unit.sv
// Light drop detector top level: APB register file, controller and datapath.
// Depends on ldd_pkg, ldd_ctrl and ldd_dp.
//
// Usage: one ADC reading per item on sample (sample_valid/sample_ready). The
// first WINDOW items after reset fill the dark baseline ring and produce no
// result; the block stays ready after each one. Afterwards, in single mode
// every item yields a result (detected, judged_value, baseline_sum) on
// result_valid/result_ready; the item passes a multiply and a compare step,
// then one ring push when no drop is seen. In the averaged modes items
// 1..GROUP-1 of a group are only added to the group sum; the last one then
// passes divide by GROUP, multiply and compare, followed by GROUP ring pushes,
// one push per cycle through the single write port, in update mode when no
// drop is seen. Hold mode never pushes.
// A finished result sits in the output register while the next item is
// taken; a following result waits in the compare step until it is taken.
// Reset clears the ring pointer, sum, priming and group counts, and loads
// drop_threshold = 50 and judge_mode = single. Registers: 0x0 drop_threshold,
// 0x4 judge_mode; write only while the block is idle.
module light_drop_detector_unit #(
    parameter int WINDOW      = 40,
    parameter int GROUP       = 5,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ldd_pkg::ADDR_W-1:0]   paddr,
    input  logic [ldd_pkg::DATA_W-1:0]   pwdata,
    output logic [ldd_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         sample_valid,
    output logic                         sample_ready,
    input  logic [SAMPLE_BITS-1:0]       sample,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic                         detected,
    output logic [ldd_pkg::JV_W-1:0]     judged_value,
    output logic [ldd_pkg::BS_W-1:0]     baseline_sum
);

    logic [ldd_pkg::THR_W-1:0]  drop_threshold_reg;
    logic [ldd_pkg::MODE_W-1:0] judge_mode_reg;
    logic                       wr_en;
    ldd_pkg::dp_cmd_t           cmd;
    ldd_pkg::dp_status_t        status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            ldd_pkg::REG_THRESHOLD: prdata = ldd_pkg::DATA_W'(drop_threshold_reg);
            ldd_pkg::REG_MODE:      prdata = ldd_pkg::DATA_W'(judge_mode_reg);
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_threshold_reg <= ldd_pkg::THR_RESET;
            judge_mode_reg     <= ldd_pkg::MODE_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                ldd_pkg::REG_THRESHOLD: drop_threshold_reg <= pwdata[ldd_pkg::THR_W-1:0];
                ldd_pkg::REG_MODE:      judge_mode_reg     <= pwdata[ldd_pkg::MODE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    ldd_ctrl #(
        .GROUP (GROUP)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .judge_mode   (judge_mode_reg),
        .status       (status),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    ldd_dp #(
        .WINDOW      (WINDOW),
        .GROUP       (GROUP),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample         (sample),
        .drop_threshold (drop_threshold_reg),
        .cmd            (cmd),
        .status         (status),
        .detected       (detected),
        .judged_value   (judged_value),
        .baseline_sum   (baseline_sum)
    );

endmodule

>>> rtl/ldd_checker.sv
// Port-level checker for the light drop detector, bound to the top level.
// Depends on light_drop_detector_unit_macros.svh and ldd_pkg.
`include "light_drop_detector_unit_macros.svh"

module ldd_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       sample_valid,
    input logic                       sample_ready,
    input logic                       result_valid,
    input logic                       result_ready,
    input logic                       detected,
    input logic [ldd_pkg::JV_W-1:0]   judged_value,
    input logic [ldd_pkg::BS_W-1:0]   baseline_sum
);

    `LDD_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(detected) && $stable(judged_value) && $stable(baseline_sum), "stalled result item changed")
    `LDD_ASSERT_IMPLY(a_result_after_busy, $rose(result_valid), !$past(sample_ready), "result item appeared without a judge step")
    `LDD_ASSERT_IMPLY(a_busy_after_item, $fell(sample_ready), $past(sample_valid), "block went busy without an item")
    `LDD_ASSERT_IMPLY(a_detect_nonzero_sum, result_valid && detected, baseline_sum != '0, "drop reported on empty baseline")

endmodule

bind light_drop_detector_unit ldd_checker u_ldd_checker (.*);

>>> sim/tb_top.sv
// Testbench for light_drop_detector_unit: APB register access, baseline priming,
// single, averaged and hold judgements checked item by item against a local predictor.
// Depends on ldd_pkg and the light_drop_detector_unit RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW_LEN       = 40;
    localparam int GROUP_LEN        = 5;
    localparam int SAMPLE_W         = 10;
    localparam int SAMPLE_MAX       = (1 << SAMPLE_W) - 1;
    localparam int SETTLE_CYCLES    = 24;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_PHASES    = 8;
    localparam int PHASE_ITEMS      = 210;
    localparam logic [ldd_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic                     detected;
        logic [ldd_pkg::JV_W-1:0] judged;
        logic [ldd_pkg::BS_W-1:0] bsum;
    } judgement_t;

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       psel         = 1'b0;
    logic                       penable      = 1'b0;
    logic                       pwrite       = 1'b0;
    logic [ldd_pkg::ADDR_W-1:0] paddr        = '0;
    logic [ldd_pkg::DATA_W-1:0] pwdata       = '0;
    logic [ldd_pkg::DATA_W-1:0] prdata;
    logic                       pready;
    logic                       sample_valid = 1'b0;
    logic                       sample_ready;
    logic [SAMPLE_W-1:0]        sample       = '0;
    logic                       result_valid;
    logic                       result_ready = 1'b0;
    logic                       detected;
    logic [ldd_pkg::JV_W-1:0]   judged_value;
    logic [ldd_pkg::BS_W-1:0]   baseline_sum;

    // predictor state
    logic [SAMPLE_W-1:0]        base_ring [WINDOW_LEN];
    int                         ring_ptr   = 0;
    int                         ring_total = 0;
    int                         primed_cnt = 0;
    int                         grp_acc    = 0;
    int                         grp_cnt    = 0;
    logic [ldd_pkg::THR_W-1:0]  thr_reg    = ldd_pkg::THR_RESET;
    logic [ldd_pkg::MODE_W-1:0] mode_reg   = ldd_pkg::MODE_RESET;

    judgement_t pending_judgements [$];
    int         mismatches   = 0;
    int         next_gap     = 0;
    bit         src_busy     = 1'b1;
    bit         sink_busy    = 1'b1;
    bit         hold_request = 1'b0;

    light_drop_detector_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .detected     (detected),
        .judged_value (judged_value),
        .baseline_sum (baseline_sum)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s", msg);
    endfunction

    task automatic ring_push(input int v);
        ring_total = ring_total - int'(base_ring[ring_ptr]) + v;
        base_ring[ring_ptr] = v[SAMPLE_W-1:0];
        ring_ptr = (ring_ptr + 1) % WINDOW_LEN;
    endtask

    task automatic judge_value(input int v, input int pushes);
        judgement_t j;
        j.detected = ring_total > WINDOW_LEN * (v + int'(thr_reg));
        j.judged   = v[ldd_pkg::JV_W-1:0];
        j.bsum     = ring_total[ldd_pkg::BS_W-1:0];
        pending_judgements.push_back(j);
        if (!j.detected)
            repeat (pushes) ring_push(v);
    endtask

    task automatic judge_sample(input logic [SAMPLE_W-1:0] s);
        if (primed_cnt < WINDOW_LEN)
        begin
            base_ring[ring_ptr] = s;
            ring_total += int'(s);
            ring_ptr = (ring_ptr + 1) % WINDOW_LEN;
            primed_cnt++;
        end
        else if (mode_reg == ldd_pkg::MODE_SINGLE)
        begin
            grp_acc = 0;
            grp_cnt = 0;
            judge_value(int'(s), 1);
        end
        else
        begin
            grp_acc += int'(s);
            grp_cnt++;
            if (grp_cnt == GROUP_LEN)
            begin
                judge_value(grp_acc / GROUP_LEN,
                            (mode_reg == ldd_pkg::MODE_AVG) ? GROUP_LEN : 0);
                grp_acc = 0;
                grp_cnt = 0;
            end
        end
    endtask

    // valid stays high across items when the next gap is zero
    task automatic send_item(input logic [SAMPLE_W-1:0] s);
        repeat (next_gap) @(posedge clk);
        sample_valid <= 1'b1;
        sample       <= s;
        do @(posedge clk); while (sample_ready !== 1'b1);
        judge_sample(s);
        next_gap = src_busy ? $urandom_range(0, 15) : 0;
        if (next_gap != 0)
            sample_valid <= 1'b0;
    endtask

    task automatic idle_input();
        if (next_gap == 0)
            sample_valid <= 1'b0;
        next_gap = 1;
    endtask

    task automatic wait_idle();
        idle_input();
        while (pending_judgements.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic idx, input logic [ldd_pkg::DATA_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == ldd_pkg::REG_THRESHOLD)
            thr_reg = val[ldd_pkg::THR_W-1:0];
        else
            mode_reg = val[ldd_pkg::MODE_W-1:0];
    endtask

    task automatic reg_check(input logic idx);
        logic [ldd_pkg::DATA_W-1:0] want;
        logic [ldd_pkg::DATA_W-1:0] mask;
        want = (idx == ldd_pkg::REG_THRESHOLD) ? ldd_pkg::DATA_W'(thr_reg)
                                               : ldd_pkg::DATA_W'(mode_reg);
        mask = (idx == ldd_pkg::REG_THRESHOLD) ?
               ldd_pkg::DATA_W'((1 << ldd_pkg::THR_W) - 1) :
               ldd_pkg::DATA_W'((1 << ldd_pkg::MODE_W) - 1);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if ((prdata & mask) !== want)
            note_mismatch($sformatf("register %0d read 0x%0h, expected 0x%0h",
                                    idx, prdata & mask, want));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // mostly near the detection edge, some anywhere, some at the rails
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int centre;
        int roll;
        int value;
        centre = ring_total / WINDOW_LEN - int'(thr_reg);
        roll   = $urandom_range(0, 99);
        if (roll < 6)
            value = 0;
        else if (roll < 12)
            value = SAMPLE_MAX;
        else if (roll < 40 || centre < 0)
            value = int'($urandom_range(0, SAMPLE_MAX));
        else
            value = centre + int'($urandom_range(0, 24)) - 12;
        if (value < 0)
            value = 0;
        if (value > SAMPLE_MAX)
            value = SAMPLE_MAX;
        return value[SAMPLE_W-1:0];
    endfunction

    // judged value right at the threshold edge of the current baseline
    task automatic send_boundary();
        int level;
        level = ring_total / WINDOW_LEN - int'(thr_reg);
        if (level < 0)
            level = 0;
        if (level > SAMPLE_MAX)
            level = SAMPLE_MAX;
        send_item(level[SAMPLE_W-1:0]);
    endtask

    initial
    begin : result_sink
        int         stall;
        judgement_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall = LONG_HOLD_CYCLES;
            end
            else
                stall = sink_busy ? $urandom_range(0, 15) : 0;
            if (stall != 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (result_valid !== 1'b1);
            if (pending_judgements.size() == 0)
                note_mismatch("result with no judgement pending");
            else
            begin
                want = pending_judgements.pop_front();
                if (detected !== want.detected)
                    note_mismatch($sformatf("detected %0b, expected %0b (judged %0d)",
                                            detected, want.detected, want.judged));
                if (judged_value !== want.judged)
                    note_mismatch($sformatf("judged_value %0d, expected %0d",
                                            judged_value, want.judged));
                if (baseline_sum !== want.bsum)
                    note_mismatch($sformatf("baseline_sum %0d, expected %0d",
                                            baseline_sum, want.bsum));
            end
        end
    end

    task automatic test_register_access();
        reg_check(ldd_pkg::REG_THRESHOLD);
        reg_check(ldd_pkg::REG_MODE);
        reg_write(ldd_pkg::REG_THRESHOLD, 32'hFFFF_FFFF);
        reg_check(ldd_pkg::REG_THRESHOLD);
        reg_write(ldd_pkg::REG_THRESHOLD, '0);
        reg_check(ldd_pkg::REG_THRESHOLD);
        reg_write(ldd_pkg::REG_MODE, ldd_pkg::DATA_W'(MODE_SPARE));
        reg_check(ldd_pkg::REG_MODE);
        reg_write(ldd_pkg::REG_THRESHOLD, ldd_pkg::DATA_W'(ldd_pkg::THR_RESET));
        // mode must be ignored while the baseline fills
        reg_write(ldd_pkg::REG_MODE, ldd_pkg::DATA_W'(ldd_pkg::MODE_AVG));
        reg_check(ldd_pkg::REG_MODE);
    endtask

    task automatic test_priming();
        send_item('0);
        send_item(10'd1020);
        repeat (WINDOW_LEN - 2) send_item(10'd510);
        wait_idle();
    endtask

    task automatic test_single_mode();
        reg_write(ldd_pkg::REG_MODE, ldd_pkg::DATA_W'(ldd_pkg::MODE_SINGLE));
        send_boundary();
        send_boundary();
        send_item('0);
        send_item(SAMPLE_W'(SAMPLE_MAX));
        wait_idle();
        reg_write(ldd_pkg::REG_THRESHOLD, '0);
        send_boundary();
        wait_idle();
        reg_write(ldd_pkg::REG_THRESHOLD, ldd_pkg::DATA_W'(SAMPLE_MAX));
        send_item('0);
        wait_idle();
        reg_write(ldd_pkg::REG_THRESHOLD, ldd_pkg::DATA_W'(ldd_pkg::THR_RESET));
    endtask

    task automatic test_group_modes();
        reg_write(ldd_pkg::REG_MODE, ldd_pkg::DATA_W'(ldd_pkg::MODE_AVG));
        repeat (GROUP_LEN - 1) send_item(SAMPLE_W'(SAMPLE_MAX));
        send_item(10'd1022);
        wait_idle();
        reg_write(ldd_pkg::REG_MODE, ldd_pkg::DATA_W'(MODE_SPARE));
        repeat (GROUP_LEN) send_item(pick_sample());
        wait_idle();
    endtask

    task automatic test_mode_switch();
        reg_write(ldd_pkg::REG_MODE, ldd_pkg::DATA_W'(ldd_pkg::MODE_AVG));
        repeat (3) send_item(pick_sample());
        wait_idle();
        // partial group dropped by single mode
        reg_write(ldd_pkg::REG_MODE, ldd_pkg::DATA_W'(ldd_pkg::MODE_SINGLE));
        send_item(pick_sample());
        wait_idle();
        reg_write(ldd_pkg::REG_MODE, ldd_pkg::DATA_W'(ldd_pkg::MODE_AVG));
        repeat (2) send_item(pick_sample());
        wait_idle();
        // partial group carried into hold mode
        reg_write(ldd_pkg::REG_MODE, ldd_pkg::DATA_W'(ldd_pkg::MODE_HOLD));
        repeat (3) send_item(pick_sample());
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        reg_write(ldd_pkg::REG_MODE, ldd_pkg::DATA_W'(ldd_pkg::MODE_SINGLE));
        src_busy     = 1'b0;
        hold_request = 1'b1;
        repeat (WINDOW_LEN) send_item(pick_sample());
        src_busy = 1'b1;
        wait_idle();
    endtask

    task automatic test_random_traffic();
        logic [ldd_pkg::MODE_W-1:0] mode_pick;
        int                         thr_pick;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_idle();
            if (p % 3 == 0)
                mode_pick = ldd_pkg::MODE_SINGLE;
            else if (p % 3 == 1)
                mode_pick = ldd_pkg::MODE_AVG;
            else
                mode_pick = (p % 2 != 0) ? MODE_SPARE : ldd_pkg::MODE_HOLD;
            if (p == 0)
                thr_pick = 0;
            else if (p == 1)
                thr_pick = SAMPLE_MAX;
            else if ($urandom_range(0, 3) != 0)
                thr_pick = $urandom_range(0, 120);
            else
                thr_pick = $urandom_range(0, SAMPLE_MAX);
            reg_write(ldd_pkg::REG_THRESHOLD, ldd_pkg::DATA_W'(thr_pick));
            reg_write(ldd_pkg::REG_MODE, ldd_pkg::DATA_W'(mode_pick));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 50 == 0)
                begin
                    src_busy  = $urandom_range(0, 3) != 0;
                    sink_busy = $urandom_range(0, 3) != 0;
                end
                send_item(pick_sample());
            end
        end
        src_busy  = 1'b1;
        sink_busy = 1'b1;
        wait_idle();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_register_access();
        test_priming();
        test_single_mode();
        test_group_modes();
        test_mode_switch();
        test_output_backpressure();
        test_random_traffic();
        wait_idle();
        if (mismatches == 0 && pending_judgements.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> light_drop_detector_unit.f
+incdir+rtl
rtl/ldd_pkg.sv
rtl/ldd_ctrl.sv
rtl/ldd_dp.sv
rtl/light_drop_detector_unit.sv
rtl/ldd_checker.sv
sim/tb_top.sv
